// ----- rtl/core/rmq_pkg.sv -----
// Package with shared types and constants for the range-minimum query core.
`default_nettype none
package rmq_pkg;
    localparam int unsigned LEN_BITS   = 11;
    localparam int unsigned DATA_BITS  = 32;
    localparam int unsigned ADDR_BITS  = 3;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 11'd1024;
    localparam logic [ADDR_BITS-1:0] REG_USED_LENGTH = 3'd0;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;
endpackage
`default_nettype wire

// ----- rtl/core/rmq_store.sv -----
// Value store: one write port and one read port with registered read data.
`default_nettype none
module rmq_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned DW    = 16
) (
    input  wire logic              i_clk,
    input  wire rmq_pkg::t_mem_ctl i_ctl,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DW-1:0]     i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic [DW-1:0]          o_rdata
);
    import rmq_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/range_minimum_query_core.sv -----
// Top level of the range-minimum query core: control, store and register port.
// Usage:
//   Items enter on i_in_valid/o_in_ready. opcode 0 stores write_value at
//   first_index; opcode 1 returns the minimum over the inclusive range
//   between first_index and second_index, in either order.
//   Every item gives one result on o_out_valid/i_out_ready; writes and
//   index errors return zero.
//   A write or an out-of-range query goes from idle straight to the done
//   state; a query over lo..hi scans the range with one store read per cycle,
//   then passes a drain state before the done state.
//   One item is in flight at a time; o_in_ready is high only while idle.
//   The result sits in an output register; if the receiver stalls, the next
//   item still runs and waits in its final state until the register frees.
//   used_length sits at byte address 0 of the APB port and resets to 1024.
//   Reset clears control state; stored values are undefined until written.
`default_nettype none
module range_minimum_query_core #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned VALUE_BITS  = 16,
    parameter int unsigned IDX_BITS    = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rmq_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [rmq_pkg::DATA_BITS-1:0] pwdata,
    output logic [rmq_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_opcode,
    input  wire logic [IDX_BITS-1:0]           i_first_index,
    input  wire logic [IDX_BITS-1:0]           i_second_index,
    input  wire logic [VALUE_BITS-1:0]         i_write_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [VALUE_BITS-1:0]              o_range_minimum,
    output logic                               o_index_error
);
    import rmq_pkg::*;

    logic [LEN_BITS-1:0]   r_len;
    t_state                r_state, n_state;
    logic [IDX_BITS-1:0]   r_addr, r_hi;
    logic [VALUE_BITS-1:0] r_best, n_best;
    logic                  r_pend, r_err;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_min;
    logic                  r_out_err;
    t_mem_ctl              w_ctl;
    logic [VALUE_BITS-1:0] w_rdata;
    logic [31:0]           w_len_eff;
    logic                  w_acc, w_range_err, w_wr_ok, w_out_free;
    logic [IDX_BITS-1:0]   w_lo, w_hi;

    assign pready = 1'b1;
    assign prdata = DATA_BITS'(r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (psel && penable && pwrite && paddr == REG_USED_LENGTH) begin
            r_len <= pwdata[LEN_BITS-1:0];
        end
    end

    assign w_len_eff   = (32'(r_len) > MAX_ENTRIES) ? 32'(MAX_ENTRIES) : 32'(r_len);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_range_err = (32'(i_first_index) >= w_len_eff) ||
                         (32'(i_second_index) >= w_len_eff);
    assign w_wr_ok     = 32'(i_first_index) < MAX_ENTRIES;
    assign w_lo        = (i_first_index < i_second_index) ? i_first_index : i_second_index;
    assign w_hi        = (i_first_index < i_second_index) ? i_second_index : i_first_index;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign n_best      = (r_pend && w_rdata < r_best) ? w_rdata : r_best;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_opcode == OP_QUERY && !w_range_err) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_addr == r_hi) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_ctl.wr_en = 1'b0;
        w_ctl.rd_en = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                w_ctl.wr_en = i_in_valid && i_opcode == OP_WRITE && w_wr_ok;
            end
            ST_SCAN: w_ctl.rd_en = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_ctl.rd_en;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_addr <= w_lo;
                r_hi   <= w_hi;
                r_err  <= (i_opcode == OP_QUERY) && w_range_err;
                if (i_opcode == OP_WRITE || w_range_err) begin
                    r_best <= '0;
                end else begin
                    r_best <= '1;
                end
            end
            ST_SCAN: begin
                r_addr <= r_addr + 1'b1;
                r_best <= n_best;
            end
            ST_DRAIN: r_best <= n_best;
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_min <= r_best;
                    r_out_err <= r_err;
                end
            end
            default: ;
        endcase
    end

    rmq_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_BITS),
        .DW    (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_waddr (i_first_index),
        .i_wdata (i_write_value),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_range_minimum = r_out_min;
    assign o_index_error   = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> o_range_minimum == '0)
        else $error("error result with nonzero minimum");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_addr <= r_hi)
        else $error("scan address passed range end");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.wr_en |-> r_state == ST_IDLE && !w_ctl.rd_en)
        else $error("store write outside idle");
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && w_out_free |=> o_out_valid)
        else $error("finished item not presented");
endmodule
`default_nettype wire

// ----- tb/sv/rmq_scoreboard.sv -----
// Checker for the range-minimum query core: predicts each result and compares it.
`default_nettype none
module rmq_scoreboard (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_write,
    input  wire logic [10:0] i_cfg_length,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_opcode,
    input  wire logic [9:0]  i_first_index,
    input  wire logic [9:0]  i_second_index,
    input  wire logic [15:0] i_write_value,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] i_range_minimum,
    input  wire logic        i_index_error,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_results
);
    import rmq_pkg::*;

    typedef struct packed {
        logic [15:0] minimum;
        logic        err;
    } t_answer;

    logic [15:0] stored_values [1024];
    logic [10:0] active_length;
    t_answer     answer_fifo [$];

    function automatic t_answer predict_answer(logic op, logic [9:0] a, logic [9:0] b);
        t_answer     ans;
        logic [9:0]  lo;
        logic [9:0]  hi;
        logic [10:0] len;
        ans = '0;
        len = (active_length > 11'd1024) ? 11'd1024 : active_length;
        if (op == OP_QUERY) begin
            if ({1'b0, a} >= len || {1'b0, b} >= len) begin
                ans.err = 1'b1;
            end else begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                ans.minimum = stored_values[lo];
                for (int k = lo; k <= hi; k++) begin
                    if (stored_values[k] < ans.minimum) ans.minimum = stored_values[k];
                end
            end
        end
        return ans;
    endfunction

    assign o_pending = answer_fifo.size();

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            active_length <= LEN_RESET;
            o_mismatches  <= 0;
            o_results     <= 0;
        end else begin
            if (i_cfg_write) active_length <= i_cfg_length;
            if (i_in_valid && i_in_ready) begin
                answer_fifo = {answer_fifo,
                    predict_answer(i_opcode, i_first_index, i_second_index)};
                if (i_opcode == OP_WRITE) stored_values[i_first_index] = i_write_value;
            end
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (answer_fifo.size() == 0) begin
                    if (o_mismatches < 10) $display("unexpected result %h/%b",
                        i_range_minimum, i_index_error);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = answer_fifo.pop_front();
                    if (want.minimum !== i_range_minimum || want.err !== i_index_error) begin
                        if (o_mismatches < 10)
                            $display("mismatch: expected min %h err %b, got min %h err %b",
                                want.minimum, want.err, i_range_minimum, i_index_error);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench top for the range-minimum query core: stimulus, register writes and verdict.
`default_nettype none
module testbench;
    import rmq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [9:0]  first_index;
    logic [9:0]  second_index;
    logic [15:0] write_value;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] range_minimum;
    logic        index_error;
    int          mismatches;
    int          pending;
    int          results;
    int          cycles;
    int          queries;
    bit          long_stall;

    range_minimum_query_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_opcode(opcode),
        .i_first_index(first_index), .i_second_index(second_index),
        .i_write_value(write_value), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_range_minimum(range_minimum), .o_index_error(index_error)
    );

    rmq_scoreboard checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_write(psel && penable && pwrite && pready && paddr == REG_USED_LENGTH),
        .i_cfg_length(pwdata[10:0]),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_opcode(opcode),
        .i_first_index(first_index), .i_second_index(second_index),
        .i_write_value(write_value), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_range_minimum(range_minimum), .i_index_error(index_error),
        .o_mismatches(mismatches), .o_pending(pending), .o_results(results)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("timeout");
            $display("** range_minimum_query_core: FAILED **");
            $finish;
        end
    end

    task automatic write_length(logic [10:0] len);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_USED_LENGTH; pwdata <= {21'd0, len};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_item(logic op, logic [9:0] a, logic [9:0] b, logic [15:0] v);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1; opcode <= op; first_index <= a; second_index <= b;
        write_value <= v;
        do @(posedge clk); while (!in_ready);
        if (op == OP_QUERY) queries++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (1100) @(negedge clk);
    endtask

    task automatic random_queries(int count, logic [9:0] top);
        logic [9:0] a;
        logic [9:0] b;
        logic [9:0] step;
        int         pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            a = 10'($urandom_range(0, top));
            step = 10'($urandom_range(0, 15));
            if (pick < 5) b = (11'(a) + 11'(step) > 11'(top)) ? top : a + step;
            else b = 10'($urandom_range(0, top));
            if (pick == 9) begin
                a = 10'($urandom);
                b = 10'($urandom);
                if ({a, b} != 0 && a <= top && b <= top) b = top;
            end
            if (pick == 8) begin
                send_item(OP_WRITE, 10'($urandom_range(0, top)), 10'($urandom),
                    16'($urandom));
            end else begin
                send_item(OP_QUERY, a, b, 16'($urandom));
            end
        end
    endtask

    always @(negedge clk) begin
        int wait_cycles;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (long_stall) begin
            out_ready <= 1'b0;
            repeat (200) @(negedge clk);
            long_stall = 1'b0;
        end else begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (wait_cycles != 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        cycles = 0; queries = 0; long_stall = 1'b0;
        rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; opcode = OP_WRITE; first_index = '0; second_index = '0;
        write_value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(OP_WRITE, 10'd0, 10'h3ff, 16'hffff);
        send_item(OP_WRITE, 10'd1023, 10'd0, 16'h0000);
        send_item(OP_WRITE, 10'd1, 10'd0, 16'h5555);
        send_item(OP_WRITE, 10'd2, 10'd0, 16'haaaa);
        send_item(OP_QUERY, 10'd0, 10'd0, 16'hffff);
        send_item(OP_QUERY, 10'd2, 10'd0, 16'd0);
        send_item(OP_QUERY, 10'd0, 10'd2, 16'd0);
        send_item(OP_QUERY, 10'd1023, 10'd1023, 16'd0);
        settle();
        write_length(11'd1);
        send_item(OP_QUERY, 10'd0, 10'd0, 16'd0);
        send_item(OP_QUERY, 10'd0, 10'd1, 16'd0);
        send_item(OP_QUERY, 10'd1, 10'd0, 16'd0);
        send_item(OP_WRITE, 10'd500, 10'd0, 16'h1234);
        settle();
        write_length(11'd0);
        send_item(OP_QUERY, 10'd0, 10'd0, 16'd0);
        settle();
        write_length(11'd2047);
        send_item(OP_QUERY, 10'd1023, 10'd1023, 16'd0);
        settle();

        write_length(11'd64);
        for (int k = 3; k < 64; k++) send_item(OP_WRITE, 10'(k), 10'($urandom), 16'($urandom));
        random_queries(250, 10'd63);
        long_stall = 1'b1;
        random_queries(200, 10'd63);
        settle();
        write_length(11'd20);
        random_queries(150, 10'd30);
        settle();
        write_length(11'd1024);
        for (int k = 64; k < 1023; k += 64) begin
            send_item(OP_WRITE, 10'(k), 10'($urandom), 16'($urandom));
        end
        for (int k = 64; k < 1023; k++) send_item(OP_WRITE, 10'(k), 10'($urandom), 16'($urandom));
        random_queries(150, 10'd63);
        for (int n = 0; n < 8; n++) begin
            send_item(OP_QUERY, 10'($urandom), 10'($urandom), 16'($urandom));
        end
        settle();

        $display("run covered %0d results, %0d queries, lengths 0,1,20,64,1024,2047",
            results, queries);
        if (mismatches == 0) begin
            $display("** range_minimum_query_core: PASSED **");
        end else begin
            $display("** range_minimum_query_core: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
